FILE: src/free_list_block_allocator_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the free list block allocator
// ----------------------------------------------------------------------------
`ifndef FREE_LIST_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define FREE_LIST_BLOCK_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication, clocked on clock, off during reset
`define FLB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FLB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/flb_pkg.sv
// ----------------------------------------------------------------------------
// flb_pkg
// Shared types and constants of the free list block allocator.
// ----------------------------------------------------------------------------
package flb_pkg;

   localparam int MAX_BLOCKS_DEF = 1024;

   localparam int OP_W       = 2;
   localparam int IDX_W      = 10;
   localparam int STAT_W     = 2;
   localparam int CNT_W      = 10;
   localparam int VOL_W      = 11;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [VOL_W-1:0] VOL_RESET = 11'd1024;

   // operation codes
   localparam logic [OP_W-1:0] OP_FORMAT = 2'd0;
   localparam logic [OP_W-1:0] OP_ALLOC  = 2'd1;
   localparam logic [OP_W-1:0] OP_FREE   = 2'd2;

   // status codes
   localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
   localparam logic [STAT_W-1:0] STAT_RANGE   = 2'd2;
   localparam logic [STAT_W-1:0] STAT_ALREADY = 2'd3;

   // register index
   localparam logic REG_VOLUME_BLOCKS = 1'b0;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_EXEC,
      FSM_FMT
   } flb_state_type;

   typedef struct packed {
      logic [IDX_W-1:0]  allocated_block;
      logic [STAT_W-1:0] status;
      logic [CNT_W-1:0]  free_blocks;
   } flb_result_type;

endpackage

FILE: src/flb_mem.sv
// ----------------------------------------------------------------------------
// flb_mem
// Block table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module flb_mem #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 11
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/flb_ctrl.sv
// ----------------------------------------------------------------------------
// flb_ctrl
// Sequencer: list head, free count, read-modify-write of the block table
// and the format sweep.
// ----------------------------------------------------------------------------
module flb_ctrl #(
   parameter int MAX_BLOCKS = flb_pkg::MAX_BLOCKS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [flb_pkg::OP_W-1:0]        operation,
   input  logic [flb_pkg::IDX_W-1:0]       block_index,
   input  logic [flb_pkg::VOL_W-1:0]       volume_blocks,
   output logic                            mem_rd_en,
   output logic [$clog2(MAX_BLOCKS)-1:0]   mem_rd_addr,
   input  logic [$clog2(MAX_BLOCKS):0]     mem_rd_data,
   output logic                            mem_wr_en,
   output logic [$clog2(MAX_BLOCKS)-1:0]   mem_wr_addr,
   output logic [$clog2(MAX_BLOCKS):0]     mem_wr_data,
   output logic                            res_valid,
   output flb_pkg::flb_result_type         res,
   input  logic                            res_ready
);
   import flb_pkg::*;

   localparam int AW   = $clog2(MAX_BLOCKS);
   localparam int CW   = $clog2(MAX_BLOCKS + 1);
   localparam int CMPW = (CW > VOL_W) ? CW : VOL_W;

   flb_state_type state_ff, state_in;
   logic [AW-1:0]    head_ff, head_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    step_ff, step_in;
   logic [OP_W-1:0]  op_ff;
   logic [IDX_W-1:0] idx_ff;

   logic            accept;
   logic [CMPW-1:0] vol_ext, size_c, idx_ext, req_idx_ext;
   logic [CW-1:0]   size_cw, step_inc;
   logic            sweep_on, in_range;
   logic            link_mark;
   logic [AW-1:0]   link_next;

   assign accept      = req_valid && (state_ff == FSM_IDLE);
   assign vol_ext     = CMPW'(volume_blocks);
   assign size_c      = (vol_ext == '0) ? CMPW'(1) :
                        (vol_ext > CMPW'(MAX_BLOCKS)) ? CMPW'(MAX_BLOCKS) : vol_ext;
   assign size_cw     = size_c[CW-1:0];
   assign idx_ext     = CMPW'(idx_ff);
   assign req_idx_ext = CMPW'(block_index);
   assign in_range    = idx_ext < size_c;
   assign step_inc    = step_ff + CW'(1);
   assign sweep_on    = step_ff < size_cw;
   assign link_mark   = mem_rd_data[0];
   assign link_next   = mem_rd_data[AW:1];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (req_valid) begin
               state_in = (operation == OP_FORMAT) ? FSM_FMT : FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            if (res_ready) begin
               state_in = FSM_IDLE;
            end
         end
         FSM_FMT: begin
            if (!sweep_on && res_ready) begin
               state_in = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_stall   = (state_ff != FSM_IDLE);
      mem_rd_en   = accept;
      mem_rd_addr = (operation == OP_ALLOC) ? head_ff : req_idx_ext[AW-1:0];
      mem_wr_en   = 1'b0;
      mem_wr_addr = head_ff;
      mem_wr_data = {link_next, 1'b0};
      head_in     = head_ff;
      count_in    = count_ff;
      step_in     = accept ? CW'(1) : step_ff;
      res_valid   = 1'b0;
      res.allocated_block = '0;
      res.status          = STAT_OK;
      res.free_blocks     = CNT_W'(count_ff);
      case (state_ff)
         FSM_EXEC: begin
            if (op_ff == OP_ALLOC) begin
               if (count_ff == '0) begin
                  res.status = STAT_FULL;
               end else begin
                  res.allocated_block = IDX_W'(head_ff);
                  mem_wr_en   = res_ready;
                  mem_wr_addr = head_ff;
                  mem_wr_data = {link_next, 1'b0};
                  head_in     = res_ready ? link_next : head_ff;
                  count_in    = count_ff - CW'(1);
               end
            end else if (op_ff == OP_FREE) begin
               if (!in_range) begin
                  res.status = STAT_RANGE;
               end else if (link_mark) begin
                  res.status = STAT_ALREADY;
               end else begin
                  mem_wr_en   = res_ready;
                  mem_wr_addr = idx_ext[AW-1:0];
                  mem_wr_data = {head_ff, 1'b1};
                  head_in     = res_ready ? idx_ext[AW-1:0] : head_ff;
                  count_in    = count_ff + CW'(1);
               end
            end
            res.free_blocks = CNT_W'(count_in);
            res_valid       = 1'b1;
            if (!res_ready) begin
               count_in = count_ff;
            end
         end
         FSM_FMT: begin
            if (sweep_on) begin
               // ring link: last block points back to zero
               mem_wr_en   = 1'b1;
               mem_wr_addr = step_ff[AW-1:0];
               mem_wr_data = {((step_inc == size_cw) ? '0 : step_inc[AW-1:0]), 1'b1};
               step_in     = step_inc;
            end else begin
               res_valid       = 1'b1;
               res.free_blocks = CNT_W'(size_cw - CW'(1));
               if (res_ready) begin
                  head_in  = AW'(1);
                  count_in = size_cw - CW'(1);
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
         head_ff  <= AW'(1);
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      if (accept) begin
         op_ff  <= operation;
         idx_ff <= block_index;
      end
   end

endmodule

FILE: src/free_list_block_allocator_core.sv
// ----------------------------------------------------------------------------
// free_list_block_allocator_core
// Block allocator for one volume on a linked free list.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one item: operation (format, allocate, free) and
//   block_index. rsp_ channel returns one item per request: allocated_block,
//   status and the free count after the operation.
//   csr_ is an APB-style port holding volume_blocks at byte address 0;
//   write it only while the block is idle.
// Timing:
//   Allocate and free each do one block table read, then the update and
//   write back. The result enters the output register with the write back;
//   the next item is taken once the sequencer is back in idle.
//   Format sweeps table blocks 1 to size-1, one block per cycle, size being
//   volume_blocks clamped to 1..MAX_BLOCKS, set by the single write port.
// Reset: head = 1, free count = 0, volume_blocks = 1024; the table content
//   is undefined until a format writes it.
// Stall: rsp_stall holds the result in the output register; a further
//   result waits in the sequencer and req_stall stays high meanwhile.
// ----------------------------------------------------------------------------
module free_list_block_allocator_core #(
   parameter int MAX_BLOCKS = flb_pkg::MAX_BLOCKS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [flb_pkg::OP_W-1:0]         req_operation,
   input  logic [flb_pkg::IDX_W-1:0]        req_block_index,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [flb_pkg::IDX_W-1:0]        rsp_allocated_block,
   output logic [flb_pkg::STAT_W-1:0]       rsp_status,
   output logic [flb_pkg::CNT_W-1:0]        rsp_free_blocks,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [flb_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [flb_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [flb_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import flb_pkg::*;

   `include "free_list_block_allocator_core_assert.svh"

   localparam int AW = $clog2(MAX_BLOCKS);

   logic [VOL_W-1:0] vol_ff, vol_in;
   logic             csr_wr;
   logic             mem_rd_en, mem_wr_en;
   logic [AW-1:0]    mem_rd_addr, mem_wr_addr;
   logic [AW:0]      mem_rd_data, mem_wr_data;
   logic             res_valid, res_ready;
   flb_result_type   res;
   logic             rsp_valid_ff, rsp_valid_in;
   flb_result_type   rsp_ff, rsp_in;

   // register file
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign vol_in     = (csr_wr && csr_paddr[2] == REG_VOLUME_BLOCKS) ?
                       csr_pwdata[VOL_W-1:0] : vol_ff;
   assign csr_prdata = (csr_paddr[2] == REG_VOLUME_BLOCKS) ?
                       CSR_DATA_W'(vol_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         vol_ff <= VOL_RESET;
      end else begin
         vol_ff <= vol_in;
      end
   end

   flb_ctrl #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .operation     (req_operation),
      .block_index   (req_block_index),
      .volume_blocks (vol_ff),
      .mem_rd_en     (mem_rd_en),
      .mem_rd_addr   (mem_rd_addr),
      .mem_rd_data   (mem_rd_data),
      .mem_wr_en     (mem_wr_en),
      .mem_wr_addr   (mem_wr_addr),
      .mem_wr_data   (mem_wr_data),
      .res_valid     (res_valid),
      .res           (res),
      .res_ready     (res_ready)
   );

   // entry = {next link, free mark}
   flb_mem #(
      .DEPTH (MAX_BLOCKS),
      .WIDTH (AW + 1)
   ) u_mem (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   // output register
   assign res_ready    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = res_valid ? 1'b1 : (rsp_valid_ff && rsp_stall);
   assign rsp_in       = (res_valid && res_ready) ? res : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= res_ready ? rsp_valid_in : rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_allocated_block = rsp_ff.allocated_block;
   assign rsp_status          = rsp_ff.status;
   assign rsp_free_blocks     = rsp_ff.free_blocks;

   `FLB_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "accepted item did not make the sequencer busy")
   `FLB_ASSERT_NOW(a_full_is_empty, clock, reset, rsp_valid && rsp_status == STAT_FULL, rsp_free_blocks == '0 && rsp_allocated_block == '0, "full status with nonzero count or block")
   `FLB_ASSERT_NOW(a_block_only_on_ok, clock, reset, rsp_valid && rsp_allocated_block != '0, rsp_status == STAT_OK, "block handed out with an error status")

endmodule
